// ===== sv/tps_pkg.sv =====
// Shared types and constants for the thermal PROCHOT supervisor.
package tps_pkg;

    localparam int TEMP_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int PINS_W  = 3;

    localparam int STATUS_PROCHOT_BIT = 4;
    localparam int FRAC_ROUND_BIT     = 7;
    localparam logic [TEMP_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [IDX_W-1:0] {
        CFG_WARN_TEMP        = 3'd0,
        CFG_CLEAR_TEMP       = 3'd1,
        CFG_SHUTDOWN_TEMP    = 3'd2,
        CFG_FAIL_LIMIT       = 3'd3,
        CFG_CLEAR_POLLS      = 3'd4,
        CFG_CARRIER_DWELL_MS = 3'd5,
        CFG_SHUTDOWN_ENABLE  = 3'd6,
        CFG_CARRIER_HOT_EN   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [TEMP_W-1:0] warn_temp;
        logic [TEMP_W-1:0] clear_temp;
        logic [TEMP_W-1:0] shutdown_temp;
        logic [TEMP_W-1:0] fail_limit;
        logic [TEMP_W-1:0] clear_polls;
        logic [TIME_W-1:0] carrier_dwell_ms;
        logic              shutdown_enable;
        logic              carrier_hot_enable;
    } cfg_t;

    typedef struct packed {
        logic              thermal_due;
        logic              temp_ok;
        logic [TEMP_W-1:0] temp_whole;
        logic [TEMP_W-1:0] temp_frac;
        logic              status_ok;
        logic [TEMP_W-1:0] status_byte;
        logic              carrier_hot_pin;
        logic              rapid_pin;
        logic              lid_pin;
        logic              tamper_pin;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic              apu_prochot_on;
        logic              carrier_prochot_on;
        logic              shutdown_pulse;
        logic              warn_entered;
        logic [TEMP_W:0]   rounded_temp;
        logic              fail_alarm;
        logic              throttling;
        logic              rapid_active;
        logic              lid_active;
        logic              tamper_active;
        logic [PINS_W-1:0] pin_changed;
    } out_item_t;

    typedef struct packed {
        logic              throttle_flag;
        logic              sensor_prochot_flag;
        logic [TEMP_W-1:0] clear_poll_count;
        logic [TEMP_W-1:0] read_fail_count;
        logic              shutdown_done;
        logic              carrier_hot_flag;
        logic              carrier_clear_pending;
        logic [TIME_W-1:0] carrier_clear_start;
        logic              apu_drive;
        logic              carrier_drive;
        logic [PINS_W-1:0] last_misc_levels;
    } state_t;

endpackage

// ===== sv/thermal_prochot_supervisor_top.sv =====
// Top level of the thermal PROCHOT supervisor: request registers and result register.
//
// One input request is one monitor poll: temperature bytes, sensor status, pin
// levels and a millisecond time. Each poll produces exactly one result request
// with the PROCHOT drives, shutdown pulse, throttle entry, rounded temperature,
// fail alarm and misc pin levels with change flags.
// Channels use valid/ready; a request moves on a clock edge with both high.
// The configuration port writes one register per cycle when cfg_wr_en is high;
// write it only while no poll is in flight.
// A poll passes two register stages (input register, then the result register).
// Throughput: one poll per cycle unless the receiver stalls; the state update for
// a poll is one pass of compare and counter logic between the input register and
// the result register. When the receiver stalls, the result holds and one more
// poll may wait in the input register; in_ready drops only when both are full.
// Reset clears all supervisor state (drives released, counters zero, shutdown
// pulse rearmed) and restores the threshold registers to their defaults.
module thermal_prochot_supervisor_top
    import tps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              thermal_due,
    input  logic              temp_ok,
    input  logic [TEMP_W-1:0] temp_whole,
    input  logic [TEMP_W-1:0] temp_frac,
    input  logic              status_ok,
    input  logic [TEMP_W-1:0] status_byte,
    input  logic              carrier_hot_pin,
    input  logic              rapid_pin,
    input  logic              lid_pin,
    input  logic              tamper_pin,
    input  logic [TIME_W-1:0] now_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              apu_prochot_on,
    output logic              carrier_prochot_on,
    output logic              shutdown_pulse,
    output logic              warn_entered,
    output logic [TEMP_W:0]   rounded_temp,
    output logic              fail_alarm,
    output logic              throttling,
    output logic              rapid_active,
    output logic              lid_active,
    output logic              tamper_active,
    output logic [PINS_W-1:0] pin_changed
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t res;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    state_t    st;
    logic      advance;

    tps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // move the held poll into the result register when that slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.thermal_due     <= thermal_due;
            in_item_reg.temp_ok         <= temp_ok;
            in_item_reg.temp_whole      <= temp_whole;
            in_item_reg.temp_frac       <= temp_frac;
            in_item_reg.status_ok       <= status_ok;
            in_item_reg.status_byte     <= status_byte;
            in_item_reg.carrier_hot_pin <= carrier_hot_pin;
            in_item_reg.rapid_pin       <= rapid_pin;
            in_item_reg.lid_pin         <= lid_pin;
            in_item_reg.tamper_pin      <= tamper_pin;
            in_item_reg.now_ms          <= now_ms;
        end
        if (advance)
            out_item_reg <= res;
    end

    tps_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res),
        .st      (st)
    );

    assign out_valid          = out_valid_reg;
    assign apu_prochot_on     = out_item_reg.apu_prochot_on;
    assign carrier_prochot_on = out_item_reg.carrier_prochot_on;
    assign shutdown_pulse     = out_item_reg.shutdown_pulse;
    assign warn_entered       = out_item_reg.warn_entered;
    assign rounded_temp       = out_item_reg.rounded_temp;
    assign fail_alarm         = out_item_reg.fail_alarm;
    assign throttling         = out_item_reg.throttling;
    assign rapid_active       = out_item_reg.rapid_active;
    assign lid_active         = out_item_reg.lid_active;
    assign tamper_active      = out_item_reg.tamper_active;
    assign pin_changed        = out_item_reg.pin_changed;

`ifndef SYNTH
    // an empty result slot never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low with empty result register");

    // once shutdown was requested, no later result repeats the pulse
    a_pulse_once: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && st.shutdown_done) |=> !out_item_reg.shutdown_pulse)
        else $error("shutdown pulse repeated");

    // entering the warning band always reports throttling
    a_warn_throttles: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.warn_entered) |-> out_item_reg.throttling)
        else $error("warn entry without throttling");
`endif

endmodule

// ===== sv/tps_cfg_regs.sv =====
// Configuration register bank with reset thresholds.
module tps_cfg_regs
    import tps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warn_temp          <= 8'd95;
            cfg_reg.clear_temp         <= 8'd90;
            cfg_reg.shutdown_temp      <= 8'd105;
            cfg_reg.fail_limit         <= 8'd3;
            cfg_reg.clear_polls        <= 8'd3;
            cfg_reg.carrier_dwell_ms   <= 32'd1000;
            cfg_reg.shutdown_enable    <= 1'b0;
            cfg_reg.carrier_hot_enable <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_WARN_TEMP:        cfg_reg.warn_temp          <= cfg_data[TEMP_W-1:0];
                CFG_CLEAR_TEMP:       cfg_reg.clear_temp         <= cfg_data[TEMP_W-1:0];
                CFG_SHUTDOWN_TEMP:    cfg_reg.shutdown_temp      <= cfg_data[TEMP_W-1:0];
                CFG_FAIL_LIMIT:       cfg_reg.fail_limit         <= cfg_data[TEMP_W-1:0];
                CFG_CLEAR_POLLS:      cfg_reg.clear_polls        <= cfg_data[TEMP_W-1:0];
                CFG_CARRIER_DWELL_MS: cfg_reg.carrier_dwell_ms   <= cfg_data[TIME_W-1:0];
                CFG_SHUTDOWN_ENABLE:  cfg_reg.shutdown_enable    <= cfg_data[0];
                CFG_CARRIER_HOT_EN:   cfg_reg.carrier_hot_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/tps_core.sv =====
// Supervisor state registers and the single-pass poll update logic.
module tps_core
    import tps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t res,
    output state_t    st
);

    state_t st_reg;
    state_t st_next;

    logic [TEMP_W-1:0] eff_limit;
    logic [TEMP_W:0]   t_round;
    logic [PINS_W-1:0] misc;
    logic [TIME_W-1:0] elapsed;
    logic              seen;
    logic              pulse;
    logic              warn_in;

    assign eff_limit = (cfg.fail_limit == '0) ? TEMP_W'(1) : cfg.fail_limit;
    assign t_round   = {1'b0, item.temp_whole} + {{TEMP_W{1'b0}}, item.temp_frac[FRAC_ROUND_BIT]};
    assign misc      = ~{item.tamper_pin, item.lid_pin, item.rapid_pin};
    assign elapsed   = item.now_ms - st_reg.carrier_clear_start;
    // carrier-hot as seen before this poll's pin update
    assign seen      = cfg.carrier_hot_enable & st_reg.carrier_hot_flag;

    always_comb
    begin
        st_next = st_reg;
        pulse   = 1'b0;
        warn_in = 1'b0;

        // temperature classification
        if (item.thermal_due)
        begin
            if (item.temp_ok)
            begin
                st_next.read_fail_count = '0;
                if (t_round >= {1'b0, cfg.shutdown_temp})
                begin
                    st_next.apu_drive     = 1'b1;
                    st_next.carrier_drive = 1'b1;
                    if (cfg.shutdown_enable && !st_reg.shutdown_done)
                    begin
                        st_next.shutdown_done = 1'b1;
                        pulse = 1'b1;
                    end
                end
                else if (t_round >= {1'b0, cfg.warn_temp})
                begin
                    if (!st_reg.throttle_flag)
                    begin
                        st_next.throttle_flag = 1'b1;
                        warn_in = 1'b1;
                    end
                    st_next.apu_drive = 1'b1;
                end
                else if (st_reg.throttle_flag && t_round < {1'b0, cfg.clear_temp})
                begin
                    st_next.throttle_flag = 1'b0;
                    if (!seen && !st_reg.sensor_prochot_flag)
                    begin
                        st_next.apu_drive     = 1'b0;
                        st_next.carrier_drive = 1'b0;
                    end
                end
            end
            else
            begin
                if (st_reg.read_fail_count != COUNT_MAX)
                    st_next.read_fail_count = st_reg.read_fail_count + 1'b1;
                if (st_next.read_fail_count >= eff_limit)
                begin
                    st_next.apu_drive     = 1'b1;
                    st_next.carrier_drive = 1'b1;
                end
            end
        end

        // sensor PROCHOT with clear-poll dwell
        if (item.status_ok && item.status_byte[STATUS_PROCHOT_BIT])
        begin
            st_next.clear_poll_count    = '0;
            st_next.carrier_drive       = 1'b1;
            st_next.sensor_prochot_flag = 1'b1;
        end
        else if (st_reg.sensor_prochot_flag)
        begin
            if (st_reg.clear_poll_count != COUNT_MAX)
                st_next.clear_poll_count = st_reg.clear_poll_count + 1'b1;
            if (st_next.clear_poll_count >= cfg.clear_polls)
            begin
                st_next.clear_poll_count = '0;
                if (!st_next.throttle_flag && !seen)
                begin
                    st_next.carrier_drive       = 1'b0;
                    st_next.sensor_prochot_flag = 1'b0;
                end
            end
        end
        else
        begin
            st_next.clear_poll_count = '0;
        end

        // carrier-hot pin with millisecond dwell
        if (cfg.carrier_hot_enable)
        begin
            if (!item.carrier_hot_pin)
            begin
                if (!st_reg.carrier_hot_flag)
                begin
                    st_next.carrier_hot_flag = 1'b1;
                    st_next.apu_drive        = 1'b1;
                    st_next.carrier_drive    = 1'b1;
                end
                st_next.carrier_clear_pending = 1'b0;
            end
            else if (st_reg.carrier_hot_flag)
            begin
                if (!st_reg.carrier_clear_pending)
                begin
                    st_next.carrier_clear_pending = 1'b1;
                    st_next.carrier_clear_start   = item.now_ms;
                end
                else if (elapsed >= cfg.carrier_dwell_ms)
                begin
                    st_next.carrier_hot_flag      = 1'b0;
                    st_next.carrier_clear_pending = 1'b0;
                    if (!st_next.throttle_flag)
                        st_next.apu_drive = 1'b0;
                end
            end
        end

        st_next.last_misc_levels = misc;

        res.apu_prochot_on     = st_next.apu_drive;
        res.carrier_prochot_on = st_next.carrier_drive;
        res.shutdown_pulse     = pulse;
        res.warn_entered       = warn_in;
        res.rounded_temp       = (item.thermal_due && item.temp_ok) ? t_round : '0;
        res.fail_alarm         = (st_next.read_fail_count >= eff_limit);
        res.throttling         = st_next.throttle_flag | st_next.sensor_prochot_flag |
                                 (cfg.carrier_hot_enable & st_next.carrier_hot_flag);
        res.rapid_active       = misc[0];
        res.lid_active         = misc[1];
        res.tamper_active      = misc[2];
        res.pin_changed        = misc ^ st_reg.last_misc_levels;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (advance)
            st_reg <= st_next;
    end

    assign st = st_reg;

endmodule
